>>> hdl/touch_gesture_tracker_defines.svh
// assertion macros used by the top-level rtl file
`ifndef TOUCH_GESTURE_TRACKER_DEFINES_SVH
`define TOUCH_GESTURE_TRACKER_DEFINES_SVH
`ifndef SYNTH
// condition must hold whenever out of reset
`define TGT_ASSERT(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);
// pre in one cycle implies post in the next
`define TGT_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);
`else
`define TGT_ASSERT(lbl, clk, rstn, cond, msg)
`define TGT_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

>>> hdl/tgt_pkg.sv
package tgt_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int DECAY_DEPTH_DEF = 256;

    localparam logic [2:0] OP_DOWN   = 3'd0;
    localparam logic [2:0] OP_MOVE   = 3'd1;
    localparam logic [2:0] OP_UP     = 3'd2;
    localparam logic [2:0] OP_CANCEL = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    localparam logic [1:0] GEST_IDLE  = 2'd0;
    localparam logic [1:0] GEST_DRAG  = 2'd1;
    localparam logic [1:0] GEST_PINCH = 2'd2;

    localparam logic [2:0] REG_ROT_GAIN   = 3'd0;
    localparam logic [2:0] REG_ZOOM_FLOOR = 3'd1;
    localparam logic [2:0] REG_ZOOM_CEIL  = 3'd2;
    localparam logic [2:0] REG_TAP_WINDOW = 3'd3;
    localparam logic [2:0] REG_TAP_RADIUS = 3'd4;
    localparam logic [2:0] REG_STILL_VEL  = 3'd5;
    localparam logic [2:0] REG_DECAY_LOG  = 3'd6;

    typedef enum logic [4:0] {
        UOP_NONE, UOP_LOAD, UOP_SQRT_START, UOP_DOWN_ONE, UOP_DOWN_TWO,
        UOP_MUL_ZOOM, UOP_DIV_START, UOP_ZOOM_WB, UOP_PINCH_WB,
        UOP_MUL_DLX, UOP_WB_DLX, UOP_MUL_DLY, UOP_WB_DLY,
        UOP_DSQ_PREV, UOP_DSQ_TAP, UOP_TAP, UOP_UP, UOP_CANCEL,
        UOP_TICK_AGE, UOP_STILL, UOP_MUL_E, UOP_WB_E, UOP_MUL_IDX, UOP_WB_FACTOR,
        UOP_MUL_AX, UOP_WB_AX, UOP_MUL_AY, UOP_WB_AY,
        UOP_MUL_VX, UOP_WB_VX, UOP_MUL_VY, UOP_WB_VY
    } uop_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_DECODE, ST_SQRT_WAIT, ST_DOWN_TWO, ST_ZMUL, ST_DIV_GO, ST_DIV_WAIT,
        ST_ZWB, ST_PINCH, ST_DOWN_ONE, ST_DMUL_X, ST_DWB_X, ST_DMUL_Y, ST_DWB_Y,
        ST_UP_DSQ, ST_UP_CHECK, ST_TAP_DSQ, ST_TAP, ST_UP, ST_CANCEL,
        ST_AGE, ST_TICK_CHK, ST_STILL, ST_MUL_E, ST_WB_E, ST_MUL_IDX, ST_WB_F,
        ST_MUL_AX, ST_WB_AX, ST_MUL_AY, ST_WB_AY, ST_MUL_VX, ST_WB_VX,
        ST_MUL_VY, ST_WB_VY, ST_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0] op;
        logic       two_fingers;
        logic       pressed;
        logic       near_release;
        logic       has_spread;
        logic       moving;
        logic       sqrt_busy;
        logic       div_busy;
    } status_t;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    // signed saturation of a magnitude with a sign
    function automatic logic [31:0] sat_mag(input logic [37:0] m, input logic neg);
        logic [31:0] r;
        if (neg) begin
            if (m > 38'h0080000000) r = 32'h8000_0000;
            else r = 32'd0 - m[31:0];
        end else begin
            if (m > 38'h007FFFFFFF) r = 32'h7FFF_FFFF;
            else r = m[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        logic [31:0] r;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else r = s[31:0];
        return r;
    endfunction

    function automatic logic [63:0] chain_pow(input logic [63:0] r, input int n);
        logic [63:0] acc;
        acc = 64'd1 << 32;
        for (int i = 0; i < n; i++) acc = (acc * r) >> 32;
        return acc;
    endfunction

    // largest per-step ratio whose depth-th power stays at or above one half
    function automatic logic [63:0] decay_root(input int depth);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 64'd0;
        hi = 64'hFFFF_FFFF;
        for (int k = 0; k < 34; k++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (chain_pow(mid, depth) >= (64'd1 << 31)) lo = mid;
                else hi = mid - 64'd1;
            end
        end
        return lo;
    endfunction

    function automatic logic [16:0] frac_entry(input logic [63:0] r, input int i);
        logic [63:0] v;
        v = (chain_pow(r, i) + 64'h8000) >> 16;
        return v[16:0];
    endfunction

endpackage

>>> hdl/touch_gesture_tracker.sv
// Touch gesture tracker: takes one touch or tick beat at a time and returns one result beat
// with the rotation, zoom, flip flag and gesture after that event. An inertia tick runs
// multiply and write-back steps for the decay exponent, table factor, both angles and both
// speeds. Two-finger events run the bit-serial root (COORD_BITS+1 steps); a pinch move with
// a previous spread also runs the restoring divider (COORD_BITS+25 steps). The next beat is
// taken while a result still waits on m_tready; the result after it is held until the first
// is taken, and meanwhile no beat is accepted. Configuration writes are taken at any time
// but belong between events.
`include "touch_gesture_tracker_defines.svh"
module touch_gesture_tracker #(
    parameter int COORD_BITS = tgt_pkg::COORD_BITS_DEF,
    parameter int DECAY_TABLE_DEPTH = tgt_pkg::DECAY_DEPTH_DEF,
    localparam int IN_W = ((4 * COORD_BITS + 20 + 7) / 8) * 8,
    localparam int OUT_W = 96
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // finger_count, pos_x, pos_y, second_x, second_y, elapsed
    input  logic [IN_W-1:0]  s_tdata,
    // operation
    input  logic [2:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // rotation_about_x, rotation_about_y, zoom_level, flip_flag, gesture
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [23:0]      cfg_data
);

    tgt_pkg::status_t status;
    tgt_pkg::uop_t    uop;
    logic             emit;

    assign cfg_ready = 1'b1;

    tgt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .uop      (uop),
        .emit     (emit)
    );

    tgt_datapath #(
        .COORD_BITS        (COORD_BITS),
        .DECAY_TABLE_DEPTH (DECAY_TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .uop       (uop),
        .status    (status),
        .in_op     (s_tuser),
        .in_tdata  (s_tdata),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .emit      (emit),
        .out_tdata (m_tdata)
    );

    `TGT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "took a second beat while busy")
    `TGT_ASSERT(a_units_quiet_when_idle, aclk, aresetn, !s_tready || (!status.sqrt_busy && !status.div_busy), "iterative unit running while idle")
    `TGT_ASSERT(a_gesture_code, aclk, aresetn, !m_tvalid || (m_tdata[90:89] != 2'd3), "bad gesture code on result")

endmodule

>>> hdl/tgt_ctrl.sv
module tgt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  tgt_pkg::status_t   status,
    output tgt_pkg::uop_t      uop,
    output logic               emit
);

    tgt_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tgt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign s_tready = (state_reg == tgt_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        uop = tgt_pkg::UOP_NONE;
        emit = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            tgt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    uop = tgt_pkg::UOP_LOAD;
                    state_next = tgt_pkg::ST_DECODE;
                end
            end
            tgt_pkg::ST_DECODE: begin
                case (status.op)
                    tgt_pkg::OP_DOWN: begin
                        if (status.two_fingers) begin
                            uop = tgt_pkg::UOP_SQRT_START;
                            state_next = tgt_pkg::ST_SQRT_WAIT;
                        end else begin
                            state_next = tgt_pkg::ST_DOWN_ONE;
                        end
                    end
                    tgt_pkg::OP_MOVE: begin
                        if (status.two_fingers) begin
                            uop = tgt_pkg::UOP_SQRT_START;
                            state_next = tgt_pkg::ST_SQRT_WAIT;
                        end else if (status.pressed) begin
                            state_next = tgt_pkg::ST_DMUL_X;
                        end else begin
                            state_next = tgt_pkg::ST_EMIT;
                        end
                    end
                    tgt_pkg::OP_UP:     state_next = tgt_pkg::ST_UP_DSQ;
                    tgt_pkg::OP_CANCEL: state_next = tgt_pkg::ST_CANCEL;
                    tgt_pkg::OP_TICK:   state_next = tgt_pkg::ST_AGE;
                    default:            state_next = tgt_pkg::ST_EMIT;
                endcase
            end
            tgt_pkg::ST_SQRT_WAIT: begin
                if (!status.sqrt_busy) begin
                    if (status.op == tgt_pkg::OP_DOWN) state_next = tgt_pkg::ST_DOWN_TWO;
                    else if (status.has_spread) state_next = tgt_pkg::ST_ZMUL;
                    else state_next = tgt_pkg::ST_PINCH;
                end
            end
            tgt_pkg::ST_DOWN_TWO: begin
                uop = tgt_pkg::UOP_DOWN_TWO;
                state_next = tgt_pkg::ST_EMIT;
            end
            tgt_pkg::ST_ZMUL: begin
                uop = tgt_pkg::UOP_MUL_ZOOM;
                state_next = tgt_pkg::ST_DIV_GO;
            end
            tgt_pkg::ST_DIV_GO: begin
                uop = tgt_pkg::UOP_DIV_START;
                state_next = tgt_pkg::ST_DIV_WAIT;
            end
            tgt_pkg::ST_DIV_WAIT: begin
                if (!status.div_busy) state_next = tgt_pkg::ST_ZWB;
            end
            tgt_pkg::ST_ZWB: begin
                uop = tgt_pkg::UOP_ZOOM_WB;
                state_next = tgt_pkg::ST_PINCH;
            end
            tgt_pkg::ST_PINCH: begin
                uop = tgt_pkg::UOP_PINCH_WB;
                state_next = tgt_pkg::ST_EMIT;
            end
            tgt_pkg::ST_DOWN_ONE: begin
                uop = tgt_pkg::UOP_DOWN_ONE;
                state_next = tgt_pkg::ST_EMIT;
            end
            tgt_pkg::ST_DMUL_X: begin
                uop = tgt_pkg::UOP_MUL_DLX;
                state_next = tgt_pkg::ST_DWB_X;
            end
            tgt_pkg::ST_DWB_X: begin
                uop = tgt_pkg::UOP_WB_DLX;
                state_next = tgt_pkg::ST_DMUL_Y;
            end
            tgt_pkg::ST_DMUL_Y: begin
                uop = tgt_pkg::UOP_MUL_DLY;
                state_next = tgt_pkg::ST_DWB_Y;
            end
            tgt_pkg::ST_DWB_Y: begin
                uop = tgt_pkg::UOP_WB_DLY;
                state_next = tgt_pkg::ST_EMIT;
            end
            tgt_pkg::ST_UP_DSQ: begin
                uop = tgt_pkg::UOP_DSQ_PREV;
                state_next = tgt_pkg::ST_UP_CHECK;
            end
            tgt_pkg::ST_UP_CHECK: begin
                state_next = status.near_release ? tgt_pkg::ST_TAP_DSQ : tgt_pkg::ST_UP;
            end
            tgt_pkg::ST_TAP_DSQ: begin
                uop = tgt_pkg::UOP_DSQ_TAP;
                state_next = tgt_pkg::ST_TAP;
            end
            tgt_pkg::ST_TAP: begin
                uop = tgt_pkg::UOP_TAP;
                state_next = tgt_pkg::ST_UP;
            end
            tgt_pkg::ST_UP: begin
                uop = tgt_pkg::UOP_UP;
                state_next = tgt_pkg::ST_EMIT;
            end
            tgt_pkg::ST_CANCEL: begin
                uop = tgt_pkg::UOP_CANCEL;
                state_next = tgt_pkg::ST_EMIT;
            end
            tgt_pkg::ST_AGE: begin
                uop = tgt_pkg::UOP_TICK_AGE;
                state_next = tgt_pkg::ST_TICK_CHK;
            end
            tgt_pkg::ST_TICK_CHK: begin
                if (status.pressed) state_next = tgt_pkg::ST_EMIT;
                else if (status.moving) state_next = tgt_pkg::ST_MUL_E;
                else state_next = tgt_pkg::ST_STILL;
            end
            tgt_pkg::ST_STILL: begin
                uop = tgt_pkg::UOP_STILL;
                state_next = tgt_pkg::ST_EMIT;
            end
            tgt_pkg::ST_MUL_E: begin
                uop = tgt_pkg::UOP_MUL_E;
                state_next = tgt_pkg::ST_WB_E;
            end
            tgt_pkg::ST_WB_E: begin
                uop = tgt_pkg::UOP_WB_E;
                state_next = tgt_pkg::ST_MUL_IDX;
            end
            tgt_pkg::ST_MUL_IDX: begin
                uop = tgt_pkg::UOP_MUL_IDX;
                state_next = tgt_pkg::ST_WB_F;
            end
            tgt_pkg::ST_WB_F: begin
                uop = tgt_pkg::UOP_WB_FACTOR;
                state_next = tgt_pkg::ST_MUL_AX;
            end
            tgt_pkg::ST_MUL_AX: begin
                uop = tgt_pkg::UOP_MUL_AX;
                state_next = tgt_pkg::ST_WB_AX;
            end
            tgt_pkg::ST_WB_AX: begin
                uop = tgt_pkg::UOP_WB_AX;
                state_next = tgt_pkg::ST_MUL_AY;
            end
            tgt_pkg::ST_MUL_AY: begin
                uop = tgt_pkg::UOP_MUL_AY;
                state_next = tgt_pkg::ST_WB_AY;
            end
            tgt_pkg::ST_WB_AY: begin
                uop = tgt_pkg::UOP_WB_AY;
                state_next = tgt_pkg::ST_MUL_VX;
            end
            tgt_pkg::ST_MUL_VX: begin
                uop = tgt_pkg::UOP_MUL_VX;
                state_next = tgt_pkg::ST_WB_VX;
            end
            tgt_pkg::ST_WB_VX: begin
                uop = tgt_pkg::UOP_WB_VX;
                state_next = tgt_pkg::ST_MUL_VY;
            end
            tgt_pkg::ST_MUL_VY: begin
                uop = tgt_pkg::UOP_MUL_VY;
                state_next = tgt_pkg::ST_WB_VY;
            end
            tgt_pkg::ST_WB_VY: begin
                uop = tgt_pkg::UOP_WB_VY;
                state_next = tgt_pkg::ST_EMIT;
            end
            tgt_pkg::ST_EMIT: begin
                // result register must be free before it is overwritten
                if (!out_valid_reg || m_tready) begin
                    emit = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = tgt_pkg::ST_IDLE;
                end
            end
            default: state_next = tgt_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> hdl/tgt_datapath.sv
module tgt_datapath #(
    parameter int COORD_BITS = tgt_pkg::COORD_BITS_DEF,
    parameter int DECAY_TABLE_DEPTH = tgt_pkg::DECAY_DEPTH_DEF,
    localparam int IN_W = ((4 * COORD_BITS + 20 + 7) / 8) * 8,
    localparam int OUT_W = 96
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tgt_pkg::uop_t       uop,
    output tgt_pkg::status_t    status,
    input  logic [2:0]          in_op,
    input  logic [IN_W-1:0]     in_tdata,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic                emit,
    output logic [OUT_W-1:0]    out_tdata
);

    localparam int C = COORD_BITS;
    localparam int SN = C + 1;
    localparam int DSQ_W = 2 * C + 1;
    localparam int CMP_W = (DSQ_W > 24) ? DSQ_W : 24;
    localparam int DW = 24 + SN;
    localparam int IW = $clog2(DECAY_TABLE_DEPTH);
    localparam int SCW = $clog2(SN + 1);
    localparam int DCW = $clog2(DW + 1);
    localparam logic [63:0] ROOT = tgt_pkg::decay_root(DECAY_TABLE_DEPTH);

    logic [16:0] frac_rom [DECAY_TABLE_DEPTH];
    for (genvar g = 0; g < DECAY_TABLE_DEPTH; g++) begin : g_rom
        assign frac_rom[g] = tgt_pkg::frac_entry(ROOT, g);
    end

    // configuration
    logic [15:0] gain_reg, window_reg, still_reg, decay_reg;
    logic [23:0] floor_reg, ceil_reg;
    logic [11:0] radius_reg;

    // captured input beat
    logic [2:0]   op_reg;
    logic [3:0]   fingers_reg;
    logic [C-1:0] px_reg, py_reg, qx_reg, qy_reg;
    logic [15:0]  elapsed_reg;

    // gesture state
    logic [1:0]   mode_reg;
    logic         pressed_reg, await_reg, flip_reg;
    logic [C-1:0] prev_x_reg, prev_y_reg, tap_x_reg, tap_y_reg;
    logic [31:0]  speed_x_reg, speed_y_reg, angle_x_reg, angle_y_reg;
    logic [SN-1:0] spread_reg;
    logic [23:0]  zoom_reg, age_reg;

    // work registers
    logic [21:0]  frames_reg, e_reg;
    logic [16:0]  factor_reg;
    logic [53:0]  prod_reg;
    logic [DSQ_W-1:0] dsq_reg;
    logic [23:0]  rr_reg;

    // square root unit
    logic [2*SN-1:0] rad_reg;
    logic [SN+1:0]   srem_reg;
    logic [SN-1:0]   sroot_reg;
    logic [SCW-1:0]  scnt_reg;
    logic            sbusy_reg;

    // divider unit
    logic [DW-1:0]   quo_reg;
    logic [SN:0]     drem_reg;
    logic [DCW-1:0]  dcnt_reg;
    logic            dbusy_reg;

    // drag deltas
    logic signed [SN-1:0] dx, dy;
    logic [31:0] adx, ady;
    assign dx = $signed({1'b0, px_reg}) - $signed({1'b0, prev_x_reg});
    assign dy = $signed({1'b0, py_reg}) - $signed({1'b0, prev_y_reg});
    assign adx = dx[SN-1] ? 32'(-dx) : 32'(dx);
    assign ady = dy[SN-1] ? 32'(-dy) : 32'(dy);

    // squared distance of a selected pair of points
    logic [C-1:0] ax, ay, bx, by;
    logic [C-1:0] mdx, mdy;
    logic [DSQ_W-1:0] dsq_now;
    always_comb begin
        ax = px_reg;
        ay = py_reg;
        bx = qx_reg;
        by = qy_reg;
        case (uop)
            tgt_pkg::UOP_DSQ_PREV: begin
                bx = prev_x_reg;
                by = prev_y_reg;
            end
            tgt_pkg::UOP_DSQ_TAP: begin
                bx = tap_x_reg;
                by = tap_y_reg;
            end
            default: ;
        endcase
        mdx = (ax > bx) ? ax - bx : bx - ax;
        mdy = (ay > by) ? ay - by : by - ay;
        dsq_now = DSQ_W'(mdx) * DSQ_W'(mdx) + DSQ_W'(mdy) * DSQ_W'(mdy);
    end

    // shared multiplier operands
    logic [31:0] mul_a;
    logic [21:0] mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (uop)
            tgt_pkg::UOP_MUL_DLX: begin
                mul_a = ady;
                mul_b = 22'(gain_reg);
            end
            tgt_pkg::UOP_MUL_DLY: begin
                mul_a = adx;
                mul_b = 22'(gain_reg);
            end
            tgt_pkg::UOP_MUL_ZOOM: begin
                mul_a = 32'(zoom_reg);
                mul_b = 22'(sroot_reg);
            end
            tgt_pkg::UOP_MUL_E: begin
                mul_a = 32'(decay_reg);
                mul_b = frames_reg;
            end
            tgt_pkg::UOP_MUL_IDX: begin
                mul_a = 32'(e_reg[15:0]);
                mul_b = 22'(DECAY_TABLE_DEPTH);
            end
            tgt_pkg::UOP_MUL_AX: begin
                mul_a = tgt_pkg::abs32(speed_x_reg);
                mul_b = frames_reg;
            end
            tgt_pkg::UOP_MUL_AY: begin
                mul_a = tgt_pkg::abs32(speed_y_reg);
                mul_b = frames_reg;
            end
            tgt_pkg::UOP_MUL_VX: begin
                mul_a = tgt_pkg::abs32(speed_x_reg);
                mul_b = 22'(factor_reg);
            end
            tgt_pkg::UOP_MUL_VY: begin
                mul_a = tgt_pkg::abs32(speed_y_reg);
                mul_b = 22'(factor_reg);
            end
            default: ;
        endcase
    end

    logic [31:0] drag_d;
    logic [31:0] tick_d;
    logic [24:0] age_sum;
    logic [23:0] age_new;
    logic [IW-1:0] frac_idx;
    logic [SN+1:0] s_shift, s_trial;
    logic [SN:0]   d_shift;
    logic [DW-1:0] zclamp;
    logic          tap_hit;

    assign drag_d = tgt_pkg::sat_mag(prod_reg[37:0],
        (uop == tgt_pkg::UOP_WB_DLX) ? dy[SN-1] : dx[SN-1]);
    assign tick_d = tgt_pkg::sat_mag(prod_reg[53:16],
        (uop == tgt_pkg::UOP_WB_AX || uop == tgt_pkg::UOP_WB_VX) ?
        speed_x_reg[31] : speed_y_reg[31]);
    assign age_sum = {1'b0, age_reg} + 25'(elapsed_reg);
    assign age_new = age_sum[24] ? 24'hFF_FFFF : age_sum[23:0];
    assign frac_idx = prod_reg[16 +: IW];
    assign s_shift = {srem_reg[SN-1:0], rad_reg[2*SN-1 -: 2]};
    assign s_trial = {sroot_reg, 2'b01};
    assign d_shift = {drem_reg[SN-1:0], quo_reg[DW-1]};
    assign tap_hit = await_reg && (age_reg < 24'(window_reg)) &&
                     (CMP_W'(dsq_reg) < CMP_W'(rr_reg));

    always_comb begin
        zclamp = quo_reg;
        if (zclamp < DW'(floor_reg)) zclamp = DW'(floor_reg);
        if (zclamp > DW'(ceil_reg)) zclamp = DW'(ceil_reg);
        if (zclamp > DW'(24'hFF_FFFF)) zclamp = DW'(24'hFF_FFFF);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 54'(mul_a) * 54'(mul_b);
        if (uop == tgt_pkg::UOP_LOAD) begin
            op_reg <= in_op;
            fingers_reg <= in_tdata[3:0];
            px_reg <= in_tdata[4 +: C];
            py_reg <= in_tdata[4 + C +: C];
            qx_reg <= in_tdata[4 + 2 * C +: C];
            qy_reg <= in_tdata[4 + 3 * C +: C];
            elapsed_reg <= in_tdata[4 + 4 * C +: 16];
        end
        if (uop == tgt_pkg::UOP_DSQ_PREV || uop == tgt_pkg::UOP_DSQ_TAP) dsq_reg <= dsq_now;
        if (uop == tgt_pkg::UOP_DSQ_TAP) rr_reg <= 24'(radius_reg) * 24'(radius_reg);
        if (uop == tgt_pkg::UOP_TICK_AGE)
            frames_reg <= (22'(elapsed_reg) << 6) - (22'(elapsed_reg) << 2);
        if (uop == tgt_pkg::UOP_WB_E) e_reg <= prod_reg[37:16];
        if (uop == tgt_pkg::UOP_WB_FACTOR)
            factor_reg <= (e_reg[21:16] <= 6'd16) ? (frac_rom[frac_idx] >> e_reg[21:16]) : '0;
        if (uop == tgt_pkg::UOP_SQRT_START) begin
            rad_reg <= (2 * SN)'(dsq_now);
            srem_reg <= '0;
            sroot_reg <= '0;
        end else if (sbusy_reg) begin
            rad_reg <= rad_reg << 2;
            if (s_shift >= s_trial) begin
                srem_reg <= s_shift - s_trial;
                sroot_reg <= {sroot_reg[SN-2:0], 1'b1};
            end else begin
                srem_reg <= s_shift;
                sroot_reg <= {sroot_reg[SN-2:0], 1'b0};
            end
        end
        if (uop == tgt_pkg::UOP_DIV_START) begin
            quo_reg <= prod_reg[DW-1:0];
            drem_reg <= '0;
        end else if (dbusy_reg) begin
            if (d_shift >= {1'b0, spread_reg}) begin
                drem_reg <= d_shift - {1'b0, spread_reg};
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end else begin
                drem_reg <= d_shift;
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
        if (emit)
            out_tdata <= {5'd0, mode_reg, flip_reg, zoom_reg, angle_y_reg, angle_x_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= 16'd328;
            floor_reg <= 24'd32768;
            ceil_reg <= 24'd262144;
            window_reg <= 16'd19661;
            radius_reg <= 12'd30;
            still_reg <= 16'd66;
            decay_reg <= 16'd4855;
            mode_reg <= tgt_pkg::GEST_IDLE;
            pressed_reg <= 1'b0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            speed_x_reg <= '0;
            speed_y_reg <= '0;
            spread_reg <= '0;
            angle_x_reg <= '0;
            angle_y_reg <= '0;
            zoom_reg <= 24'd65536;
            await_reg <= 1'b0;
            age_reg <= '0;
            tap_x_reg <= '0;
            tap_y_reg <= '0;
            flip_reg <= 1'b0;
            sbusy_reg <= 1'b0;
            scnt_reg <= '0;
            dbusy_reg <= 1'b0;
            dcnt_reg <= '0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    tgt_pkg::REG_ROT_GAIN:   gain_reg <= cfg_data[15:0];
                    tgt_pkg::REG_ZOOM_FLOOR: floor_reg <= cfg_data;
                    tgt_pkg::REG_ZOOM_CEIL:  ceil_reg <= cfg_data;
                    tgt_pkg::REG_TAP_WINDOW: window_reg <= cfg_data[15:0];
                    tgt_pkg::REG_TAP_RADIUS: radius_reg <= cfg_data[11:0];
                    tgt_pkg::REG_STILL_VEL:  still_reg <= cfg_data[15:0];
                    tgt_pkg::REG_DECAY_LOG:  decay_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (uop == tgt_pkg::UOP_SQRT_START) begin
                sbusy_reg <= 1'b1;
                scnt_reg <= SCW'(SN);
            end else if (sbusy_reg) begin
                scnt_reg <= scnt_reg - 1'b1;
                if (scnt_reg == SCW'(1)) sbusy_reg <= 1'b0;
            end
            if (uop == tgt_pkg::UOP_DIV_START) begin
                dbusy_reg <= 1'b1;
                dcnt_reg <= DCW'(DW);
            end else if (dbusy_reg) begin
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == DCW'(1)) dbusy_reg <= 1'b0;
            end
            case (uop)
                tgt_pkg::UOP_DOWN_ONE: begin
                    mode_reg <= tgt_pkg::GEST_DRAG;
                    prev_x_reg <= px_reg;
                    prev_y_reg <= py_reg;
                    pressed_reg <= 1'b1;
                    speed_x_reg <= '0;
                    speed_y_reg <= '0;
                end
                tgt_pkg::UOP_DOWN_TWO, tgt_pkg::UOP_PINCH_WB: begin
                    mode_reg <= tgt_pkg::GEST_PINCH;
                    spread_reg <= sroot_reg;
                end
                tgt_pkg::UOP_ZOOM_WB: zoom_reg <= zclamp[23:0];
                tgt_pkg::UOP_WB_DLX: begin
                    angle_x_reg <= tgt_pkg::sat_add(angle_x_reg, drag_d);
                    speed_x_reg <= drag_d;
                end
                tgt_pkg::UOP_WB_DLY: begin
                    angle_y_reg <= tgt_pkg::sat_add(angle_y_reg, drag_d);
                    speed_y_reg <= drag_d;
                    prev_x_reg <= px_reg;
                    prev_y_reg <= py_reg;
                end
                tgt_pkg::UOP_TAP: begin
                    if (tap_hit) begin
                        flip_reg <= ~flip_reg;
                        await_reg <= 1'b0;
                    end else begin
                        await_reg <= 1'b1;
                        age_reg <= '0;
                        tap_x_reg <= px_reg;
                        tap_y_reg <= py_reg;
                    end
                end
                tgt_pkg::UOP_UP: begin
                    pressed_reg <= 1'b0;
                    mode_reg <= tgt_pkg::GEST_IDLE;
                    spread_reg <= '0;
                end
                tgt_pkg::UOP_CANCEL: begin
                    pressed_reg <= 1'b0;
                    mode_reg <= tgt_pkg::GEST_IDLE;
                    spread_reg <= '0;
                    speed_x_reg <= '0;
                    speed_y_reg <= '0;
                end
                tgt_pkg::UOP_TICK_AGE: begin
                    if (await_reg) begin
                        age_reg <= age_new;
                        if (age_new > 24'(window_reg)) await_reg <= 1'b0;
                    end
                end
                tgt_pkg::UOP_STILL: begin
                    speed_x_reg <= '0;
                    speed_y_reg <= '0;
                end
                tgt_pkg::UOP_WB_AX: angle_x_reg <= tgt_pkg::sat_add(angle_x_reg, tick_d);
                tgt_pkg::UOP_WB_AY: angle_y_reg <= tgt_pkg::sat_add(angle_y_reg, tick_d);
                tgt_pkg::UOP_WB_VX: speed_x_reg <= tick_d;
                tgt_pkg::UOP_WB_VY: speed_y_reg <= tick_d;
                default: ;
            endcase
        end
    end

    always_comb begin
        status.op = op_reg;
        status.two_fingers = (fingers_reg >= 4'd2);
        status.pressed = pressed_reg;
        status.near_release = (dsq_reg < DSQ_W'(25)) && (mode_reg == tgt_pkg::GEST_DRAG)
                              && pressed_reg;
        status.has_spread = (spread_reg != '0);
        status.moving = (tgt_pkg::abs32(speed_x_reg) > 32'(still_reg)) ||
                        (tgt_pkg::abs32(speed_y_reg) > 32'(still_reg));
        status.sqrt_busy = sbusy_reg;
        status.div_busy = dbusy_reg;
    end

endmodule

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W = 72;
    localparam int OUT_W = 96;
    localparam int TABLE_DEPTH = 256;
    localparam int IDLE_LIMIT = 6000;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [3:0]  fingers;
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] x2;
        logic [11:0] y2;
        logic [15:0] elapsed;
    } touch_beat_t;

    typedef struct {
        logic [31:0] rot_x;
        logic [31:0] rot_y;
        logic [23:0] zoom;
        logic        flip;
        logic [1:0]  gesture;
    } view_state_t;

    class gesture_scoreboard;
        longint unsigned decay_frac[TABLE_DEPTH];
        // settings
        longint unsigned gain, zfloor, zceil, window, radius, still, dlog;
        // tracker state
        logic [1:0] mode;
        bit pressed, awaiting, flipped;
        longint unsigned px, py, spread_prev, zoom, age, tx, ty;
        int vx, vy, ax, ay;
        view_state_t views_due[$];
        int errors;
        int checked;

        function new();
            longint unsigned lo, hi, mid, acc;
            lo = 0;
            hi = 64'hFFFF_FFFF;
            while (lo < hi) begin
                mid = lo + ((hi - lo + 1) >> 1);
                if (ratio_power(mid, TABLE_DEPTH) >= (64'd1 << 31)) lo = mid;
                else hi = mid - 1;
            end
            acc = 64'd1 << 32;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                decay_frac[i] = (acc + 64'h8000) >> 16;
                acc = (acc * lo) >> 32;
            end
            gain = 328; zfloor = 32768; zceil = 262144; window = 19661;
            radius = 30; still = 66; dlog = 4855;
            mode = tgt_pkg::GEST_IDLE; pressed = 0; awaiting = 0; flipped = 0;
            px = 0; py = 0; spread_prev = 0; zoom = 65536; age = 0; tx = 0; ty = 0;
            vx = 0; vy = 0; ax = 0; ay = 0;
            errors = 0;
            checked = 0;
        endfunction

        function longint unsigned ratio_power(longint unsigned r, int n);
            longint unsigned acc;
            acc = 64'd1 << 32;
            for (int i = 0; i < n; i++) acc = (acc * r) >> 32;
            return acc;
        endfunction

        function int clip32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'sh8000_0000;
            return int'(v);
        endfunction

        function longint unsigned magnitude(int v);
            longint s;
            s = v;
            return s < 0 ? longint'(-s) : s;
        endfunction

        // sign-magnitude product, truncated toward zero
        function int scale_toward_zero(int v, longint unsigned f);
            longint m;
            m = longint'((magnitude(v) * f) >> 16);
            return clip32(v < 0 ? -m : m);
        endfunction

        function longint unsigned span_sq(longint unsigned ax_, longint unsigned ay_,
                                          longint unsigned bx, longint unsigned by);
            longint dx, dy;
            dx = longint'(ax_) - longint'(bx);
            dy = longint'(ay_) - longint'(by);
            return dx * dx + dy * dy;
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r;
            r = 0;
            while ((r + 1) * (r + 1) <= v) r++;
            return r;
        endfunction

        function void write_reg(logic [2:0] idx, logic [23:0] val);
            case (idx)
                tgt_pkg::REG_ROT_GAIN:   gain = val[15:0];
                tgt_pkg::REG_ZOOM_FLOOR: zfloor = val;
                tgt_pkg::REG_ZOOM_CEIL:  zceil = val;
                tgt_pkg::REG_TAP_WINDOW: window = val[15:0];
                tgt_pkg::REG_TAP_RADIUS: radius = val[11:0];
                tgt_pkg::REG_STILL_VEL:  still = val[15:0];
                tgt_pkg::REG_DECAY_LOG:  dlog = val[15:0];
                default: ;
            endcase
        endfunction

        function void age_and_coast(longint unsigned el);
            longint unsigned frames, e, ip, idx, factor;
            if (awaiting) begin
                age += el;
                if (age > 24'hFFFFFF) age = 24'hFFFFFF;
                if (age > window) awaiting = 0;
            end
            if (pressed) return;
            if (magnitude(vx) > still || magnitude(vy) > still) begin
                frames = el * 60;
                e = (dlog * frames) >> 16;
                ip = e >> 16;
                idx = ((e & 64'hFFFF) * TABLE_DEPTH) >> 16;
                factor = (ip <= 16) ? (decay_frac[idx] >> ip) : 0;
                ax = clip32(longint'(ax) + scale_toward_zero(vx, frames));
                ay = clip32(longint'(ay) + scale_toward_zero(vy, frames));
                vx = scale_toward_zero(vx, factor);
                vy = scale_toward_zero(vy, factor);
            end else begin
                vx = 0;
                vy = 0;
            end
        endfunction

        function void note_beat(touch_beat_t b);
            longint unsigned spread, z;
            int dlx, dly;
            view_state_t v;
            case (b.op)
                tgt_pkg::OP_DOWN: begin
                    if (b.fingers >= 2) begin
                        mode = tgt_pkg::GEST_PINCH;
                        spread_prev = floor_root(span_sq(b.x2, b.y2, b.x, b.y));
                    end else begin
                        mode = tgt_pkg::GEST_DRAG;
                        px = b.x; py = b.y;
                        pressed = 1;
                        vx = 0; vy = 0;
                    end
                end
                tgt_pkg::OP_MOVE: begin
                    if (b.fingers >= 2) begin
                        spread = floor_root(span_sq(b.x2, b.y2, b.x, b.y));
                        mode = tgt_pkg::GEST_PINCH;
                        if (spread_prev > 0) begin
                            z = (zoom * spread) / spread_prev;
                            if (z < zfloor) z = zfloor;
                            if (z > zceil) z = zceil;
                            if (z > 24'hFFFFFF) z = 24'hFFFFFF;
                            zoom = z;
                        end
                        spread_prev = spread;
                    end else if (pressed) begin
                        dly = clip32((longint'(b.x) - longint'(px)) * longint'(gain));
                        dlx = clip32((longint'(b.y) - longint'(py)) * longint'(gain));
                        ax = clip32(longint'(ax) + dlx);
                        ay = clip32(longint'(ay) + dly);
                        vx = dlx; vy = dly;
                        px = b.x; py = b.y;
                    end
                end
                tgt_pkg::OP_UP: begin
                    if (mode == tgt_pkg::GEST_DRAG && pressed &&
                        span_sq(b.x, b.y, px, py) < 25) begin
                        if (awaiting && age < window &&
                            span_sq(b.x, b.y, tx, ty) < radius * radius) begin
                            flipped = !flipped;
                            awaiting = 0;
                        end else begin
                            awaiting = 1;
                            age = 0;
                            tx = b.x; ty = b.y;
                        end
                    end
                    pressed = 0; mode = tgt_pkg::GEST_IDLE; spread_prev = 0;
                end
                tgt_pkg::OP_CANCEL: begin
                    pressed = 0; mode = tgt_pkg::GEST_IDLE;
                    vx = 0; vy = 0;
                    spread_prev = 0;
                end
                tgt_pkg::OP_TICK: age_and_coast(b.elapsed);
                default: ;
            endcase
            v.rot_x = ax;
            v.rot_y = ay;
            v.zoom = zoom[23:0];
            v.flip = flipped;
            v.gesture = mode;
            views_due.push_back(v);
        endfunction

        function void check_view(logic [OUT_W-1:0] d);
            view_state_t want, got;
            got.rot_x = d[31:0];
            got.rot_y = d[63:32];
            got.zoom = d[87:64];
            got.flip = d[88];
            got.gesture = d[90:89];
            checked++;
            if (views_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", d);
                return;
            end
            want = views_due.pop_front();
            if (got.rot_x !== want.rot_x || got.rot_y !== want.rot_y ||
                got.zoom !== want.zoom || got.flip !== want.flip ||
                got.gesture !== want.gesture || d[95:91] !== 5'd0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at result %0d: want rx %h ry %h z %h f %b g %0d, got rx %h ry %h z %h f %b g %0d",
                             checked, want.rot_x, want.rot_y, want.zoom, want.flip,
                             want.gesture, got.rot_x, got.rot_y, got.zoom, got.flip,
                             got.gesture);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn;
    logic s_tvalid, s_tready;
    logic [IN_W-1:0] s_tdata;
    logic [2:0] s_tuser;
    logic m_tvalid, m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_valid, cfg_ready;
    logic [2:0] cfg_index;
    logic [23:0] cfg_data;

    gesture_scoreboard sb = new();
    int beats_sent = 0;
    int idle_cycles = 0;
    int stall_requests = 0;
    int stalls_served = 0;
    bit gapless = 0;

    touch_gesture_tracker i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    function automatic int pick_gap();
        int r;
        if (gapless) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [11:0] nudge(logic [11:0] c, int d);
        int v;
        v = int'(c) + $urandom_range(0, 2 * d) - d;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[11:0];
    endfunction

    // receiver: random backpressure plus requested long hold-offs
    int hold_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_view(m_tdata);
            if (stall_requests != stalls_served) begin
                stalls_served = stall_requests;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (gapless) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
            !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic send_beat(logic [2:0] op, logic [3:0] f, logic [11:0] x, logic [11:0] y,
                             logic [11:0] x2, logic [11:0] y2, logic [15:0] el);
        touch_beat_t b;
        int gap;
        b.op = op; b.fingers = f; b.x = x; b.y = y; b.x2 = x2; b.y2 = y2; b.elapsed = el;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'd0, el, y2, x2, y, x, f};
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(b);
        beats_sent++;
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.views_due.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic load_settings(logic [23:0] g, logic [23:0] zf, logic [23:0] zc,
                                 logic [23:0] tw, logic [23:0] tr, logic [23:0] sv,
                                 logic [23:0] dl);
        write_cfg(tgt_pkg::REG_ROT_GAIN, g);
        write_cfg(tgt_pkg::REG_ZOOM_FLOOR, zf);
        write_cfg(tgt_pkg::REG_ZOOM_CEIL, zc);
        write_cfg(tgt_pkg::REG_TAP_WINDOW, tw);
        write_cfg(tgt_pkg::REG_TAP_RADIUS, tr);
        write_cfg(tgt_pkg::REG_STILL_VEL, sv);
        write_cfg(tgt_pkg::REG_DECAY_LOG, dl);
    endtask

    task automatic directed_events();
        send_beat(tgt_pkg::OP_DOWN, 4'd1, 12'd0, 12'd0, 12'd0, 12'd0, 16'd0);
        send_beat(tgt_pkg::OP_MOVE, 4'd1, 12'd4095, 12'd4095, 12'd0, 12'd0, 16'd0);
        send_beat(tgt_pkg::OP_MOVE, 4'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 16'hFFFF);
        send_beat(tgt_pkg::OP_MOVE, 4'd1, 12'd40, 12'd10, 12'd0, 12'd0, 16'd0);
        send_beat(tgt_pkg::OP_UP, 4'd0, 12'd40, 12'd10, 12'd0, 12'd0, 16'd0);
        send_beat(tgt_pkg::OP_TICK, 4'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'd1000);
        send_beat(tgt_pkg::OP_TICK, 4'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'hFFFF);
        send_beat(tgt_pkg::OP_TICK, 4'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'd0);
        // double tap toggles the flip flag
        send_beat(tgt_pkg::OP_DOWN, 4'd0, 12'd100, 12'd100, 12'd0, 12'd0, 16'd0);
        send_beat(tgt_pkg::OP_UP, 4'd1, 12'd101, 12'd101, 12'd0, 12'd0, 16'd0);
        send_beat(tgt_pkg::OP_TICK, 4'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'd1000);
        send_beat(tgt_pkg::OP_DOWN, 4'd1, 12'd102, 12'd100, 12'd0, 12'd0, 16'd0);
        send_beat(tgt_pkg::OP_UP, 4'd1, 12'd102, 12'd100, 12'd0, 12'd0, 16'd0);
        // pinch: far corners, then shrink and grow into both limits
        send_beat(tgt_pkg::OP_DOWN, 4'd2, 12'd0, 12'd0, 12'd4095, 12'd4095, 16'd0);
        send_beat(tgt_pkg::OP_MOVE, 4'd15, 12'd0, 12'd0, 12'd100, 12'd0, 16'd0);
        send_beat(tgt_pkg::OP_MOVE, 4'd2, 12'd0, 12'd0, 12'd4095, 12'd0, 16'd0);
        send_beat(tgt_pkg::OP_UP, 4'd2, 12'd0, 12'd0, 12'd0, 12'd0, 16'd0);
        // move while not pressed, pinch move with no prior spread
        send_beat(tgt_pkg::OP_MOVE, 4'd1, 12'd500, 12'd500, 12'd0, 12'd0, 16'd0);
        send_beat(tgt_pkg::OP_MOVE, 4'd3, 12'd10, 12'd10, 12'd10, 12'd10, 16'd0);
        send_beat(tgt_pkg::OP_MOVE, 4'd3, 12'd10, 12'd10, 12'd30, 12'd10, 16'd0);
        send_beat(tgt_pkg::OP_CANCEL, 4'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'd0);
        send_beat(3'd5, 4'd15, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'hFFFF);
        send_beat(3'd6, 4'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'd0);
        send_beat(3'd7, 4'd5, 12'd7, 12'd9, 12'd11, 12'd13, 16'd17);
    endtask

    task automatic random_events(int count);
        int stop_at, kind, n;
        logic [11:0] x, y, x2, y2;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
            if (kind < 35) begin
                send_beat(tgt_pkg::OP_DOWN, $urandom_range(0, 1), x, y, $urandom, $urandom,
                          $urandom);
                n = $urandom_range(1, 8);
                repeat (n) begin
                    if ($urandom_range(0, 9) == 0) begin
                        x = $urandom_range(0, 4095);
                        y = $urandom_range(0, 4095);
                    end else begin
                        x = nudge(x, 64);
                        y = nudge(y, 64);
                    end
                    if ($urandom_range(0, 5) == 0)
                        send_beat(tgt_pkg::OP_TICK, $urandom, x, y, 0, 0,
                                  $urandom_range(0, 2000));
                    send_beat(tgt_pkg::OP_MOVE, $urandom_range(0, 1), x, y, $urandom,
                              $urandom, $urandom);
                end
                send_beat($urandom_range(0, 5) == 0 ? tgt_pkg::OP_CANCEL : tgt_pkg::OP_UP,
                          $urandom_range(0, 1), nudge(x, 2), nudge(y, 2), 0, 0, 0);
                repeat ($urandom_range(0, 4))
                    send_beat(tgt_pkg::OP_TICK, $urandom, 0, 0, 0, 0, $urandom_range(0, 3000));
            end else if (kind < 55) begin
                x2 = $urandom_range(0, 4095);
                y2 = $urandom_range(0, 4095);
                send_beat(tgt_pkg::OP_DOWN, $urandom_range(2, 15), x, y, x2, y2, $urandom);
                n = $urandom_range(1, 6);
                repeat (n) begin
                    x = nudge(x, 200);
                    y = nudge(y, 200);
                    x2 = nudge(x2, 200);
                    y2 = nudge(y2, 200);
                    send_beat(tgt_pkg::OP_MOVE, $urandom_range(2, 15), x, y, x2, y2, $urandom);
                end
                send_beat($urandom_range(0, 4) == 0 ? tgt_pkg::OP_CANCEL : tgt_pkg::OP_UP,
                          $urandom, x, y, x2, y2, 0);
            end else if (kind < 75) begin
                repeat (2) begin
                    send_beat(tgt_pkg::OP_DOWN, $urandom_range(0, 1), x, y, 0, 0, 0);
                    send_beat(tgt_pkg::OP_UP, $urandom_range(0, 1), nudge(x, 3), nudge(y, 3),
                              0, 0, 0);
                    send_beat(tgt_pkg::OP_TICK, 0, 0, 0, 0, 0, $urandom_range(0, 12000));
                    x = nudge(x, 40);
                    y = nudge(y, 40);
                end
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 6))
                    send_beat(tgt_pkg::OP_TICK, $urandom, $urandom, $urandom, $urandom,
                              $urandom,
                              $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 4000));
            end else begin
                send_beat($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        m_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_events();
        drain();

        // reset settings, with a long output hold-off while input keeps coming
        stall_requests++;
        random_events(350);
        drain();

        load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                      24'hFFFFFF, 24'hFFFFFF);
        write_cfg(REG_UNUSED, 24'h123456);
        random_events(275);
        drain();

        load_settings(0, 0, 0, 0, 0, 0, 0);
        random_events(275);
        drain();

        // floor above ceiling
        load_settings(24'd1000, 24'd300000, 24'd20000, 24'd40000, 24'd4095, 24'd1, 24'd200);
        gapless = 1;
        random_events(275);
        drain();
        gapless = 0;

        load_settings(24'd65535, 24'd1, 24'hFFFFFF, 24'd65535, 24'd100, 24'd0, 24'd65535);
        random_events(275);
        drain();

        load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        stall_requests++;
        random_events(350);
        drain();

        $display("ran %0d event beats, checked %0d result beats over 6 register settings",
                 beats_sent, sb.checked);
        $display("covered drags, pinches with zoom clamping, double taps and inertia ticks");
        if (sb.errors == 0 && sb.views_due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.views_due.size());
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
